// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/race_pkg.sv
// ---------------------------------------------------------------------------
// race_pkg
// Types, constants and microcode table of the RESP array command encoder.
// ---------------------------------------------------------------------------
package race_pkg;

  localparam int CNT_W     = 10;
  localparam int LEN_W     = 17;
  localparam int BYTE_W    = 8;
  localparam int MLEN_W    = 24;
  localparam int BCD_DIGITS = 5;
  localparam int DIG_PTR_W = $clog2(BCD_DIGITS);
  localparam int STEP_W    = $clog2(LEN_W + 1);
  localparam int PC_W      = 5;

  localparam int MAX_ELEMENTS       = 999;
  localparam int MAX_ELEMENT_LENGTH = 99999;

  localparam logic [MLEN_W-1:0] MLEN_MAX = '1;

  // ASCII
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
  localparam logic [BYTE_W-1:0] CH_NONE   = 8'h00;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BULK  = 2'd1,
    CMD_NIL   = 2'd2,
    CMD_DATA  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    UOP_IDLE,
    UOP_CHAR,
    UOP_LOAD_TOTAL,
    UOP_LOAD_LEN,
    UOP_DABBLE,
    UOP_DIGITS,
    UOP_DATA,
    UOP_ERROR
  } uop_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_IF_NOT_TAIL
  } last_t;

  // SEQ: pc+1. ALWAYS: jmp. LOOP: stay while work remains, else pc+1.
  // NIL: jmp on nil element, else pc+1. TAIL: jmp when a CR LF tail follows,
  // else back to idle.
  typedef enum logic [2:0] {
    COND_SEQ,
    COND_ALWAYS,
    COND_LOOP,
    COND_NIL,
    COND_TAIL
  } cond_t;

  typedef struct packed {
    uop_t               uop;
    logic [BYTE_W-1:0]  ch;
    last_t              last_mode;
    cond_t              cond;
    logic [PC_W-1:0]    jmp;
  } ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] PC_HSTAR   = 5'd1;
  localparam logic [PC_W-1:0] PC_HLOAD   = 5'd2;
  localparam logic [PC_W-1:0] PC_HDAB    = 5'd3;
  localparam logic [PC_W-1:0] PC_HDIG    = 5'd4;
  localparam logic [PC_W-1:0] PC_HCR     = 5'd5;
  localparam logic [PC_W-1:0] PC_HLF     = 5'd6;
  localparam logic [PC_W-1:0] PC_BDOLLAR = 5'd7;
  localparam logic [PC_W-1:0] PC_BLOAD   = 5'd8;
  localparam logic [PC_W-1:0] PC_BDAB    = 5'd9;
  localparam logic [PC_W-1:0] PC_BDIG    = 5'd10;
  localparam logic [PC_W-1:0] PC_BCR     = 5'd11;
  localparam logic [PC_W-1:0] PC_BLF     = 5'd12;
  localparam logic [PC_W-1:0] PC_NMINUS  = 5'd13;
  localparam logic [PC_W-1:0] PC_NONE    = 5'd14;
  localparam logic [PC_W-1:0] PC_TCR     = 5'd15;
  localparam logic [PC_W-1:0] PC_TLF     = 5'd16;
  localparam logic [PC_W-1:0] PC_DATA    = 5'd17;
  localparam logic [PC_W-1:0] PC_ERROR   = 5'd18;

  function automatic ctrl_t mk_word(input uop_t uop, input logic [BYTE_W-1:0] ch,
                                    input last_t lm, input cond_t cond,
                                    input logic [PC_W-1:0] jmp);
    ctrl_t w;
    w.uop       = uop;
    w.ch        = ch;
    w.last_mode = lm;
    w.cond      = cond;
    w.jmp       = jmp;
    return w;
  endfunction

  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      // array head: '*' count CR LF
      PC_HSTAR:   w = mk_word(UOP_CHAR, CH_STAR, LAST_NO, COND_SEQ, PC_IDLE);
      PC_HLOAD:   w = mk_word(UOP_LOAD_TOTAL, CH_NONE, LAST_NO, COND_SEQ, PC_IDLE);
      PC_HDAB:    w = mk_word(UOP_DABBLE, CH_NONE, LAST_NO, COND_LOOP, PC_IDLE);
      PC_HDIG:    w = mk_word(UOP_DIGITS, CH_NONE, LAST_NO, COND_LOOP, PC_IDLE);
      PC_HCR:     w = mk_word(UOP_CHAR, CH_CR, LAST_NO, COND_SEQ, PC_IDLE);
      PC_HLF:     w = mk_word(UOP_CHAR, CH_LF, LAST_NO, COND_SEQ, PC_IDLE);
      // element head: '$' then length or "-1"
      PC_BDOLLAR: w = mk_word(UOP_CHAR, CH_DOLLAR, LAST_NO, COND_NIL, PC_NMINUS);
      PC_BLOAD:   w = mk_word(UOP_LOAD_LEN, CH_NONE, LAST_NO, COND_SEQ, PC_IDLE);
      PC_BDAB:    w = mk_word(UOP_DABBLE, CH_NONE, LAST_NO, COND_LOOP, PC_IDLE);
      PC_BDIG:    w = mk_word(UOP_DIGITS, CH_NONE, LAST_NO, COND_LOOP, PC_IDLE);
      PC_BCR:     w = mk_word(UOP_CHAR, CH_CR, LAST_NO, COND_SEQ, PC_IDLE);
      PC_BLF:     w = mk_word(UOP_CHAR, CH_LF, LAST_IF_NOT_TAIL, COND_TAIL, PC_TCR);
      PC_NMINUS:  w = mk_word(UOP_CHAR, CH_MINUS, LAST_NO, COND_SEQ, PC_IDLE);
      PC_NONE:    w = mk_word(UOP_CHAR, CH_ONE, LAST_NO, COND_SEQ, PC_IDLE);
      // closing CR LF
      PC_TCR:     w = mk_word(UOP_CHAR, CH_CR, LAST_NO, COND_SEQ, PC_IDLE);
      PC_TLF:     w = mk_word(UOP_CHAR, CH_LF, LAST_YES, COND_ALWAYS, PC_IDLE);
      PC_DATA:    w = mk_word(UOP_DATA, CH_NONE, LAST_IF_NOT_TAIL, COND_TAIL, PC_TCR);
      PC_ERROR:   w = mk_word(UOP_ERROR, CH_NONE, LAST_YES, COND_ALWAYS, PC_IDLE);
      default:    w = mk_word(UOP_IDLE, CH_NONE, LAST_NO, COND_ALWAYS, PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

// File: hdl/resp_array_command_encoder.sv
// ---------------------------------------------------------------------------
// resp_array_command_encoder
// Serializes commands as RESP arrays of bulk strings, one byte per transaction.
// ---------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid / in_stall     | command, count_or_length, data_byte
//  out     | out_valid / out_stall   | out_byte, last, error, message_done,
//          |                         | message_length
//
//  Sequence: a start only updates the counters. A payload byte is accepted,
//  then emitted, followed by CR LF when it closes the element. An error emits
//  one zero byte. A bulk element head is accepted, loads its length, converts
//  it to BCD, one shift-add-3 step per cycle, and emits its bytes; a nil one
//  emits $-1 CR LF. The first element adds the array head: load, BCD, bytes.
//  The microcode sequencer handles one transaction at a time.
//  Reset: rst is synchronous, active high; clears the architectural counters,
//  the sequencer and out_valid. Output stall freezes the sequencer on any byte-emitting step.
//
`include "assert_macros.svh"

module resp_array_command_encoder (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [race_pkg::LEN_W-1:0]    count_or_length,
  input  logic [race_pkg::BYTE_W-1:0]   data_byte,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [race_pkg::BYTE_W-1:0]   out_byte,
  output logic                          last,
  output logic                          error,
  output logic                          message_done,
  output logic [race_pkg::MLEN_W-1:0]   message_length
);
  import race_pkg::*;

  // -------------------------------------------------------------------------
  // Architectural state
  // -------------------------------------------------------------------------
  logic [CNT_W-1:0]  element_total, element_total_next;
  logic [CNT_W-1:0]  element_count, element_count_next;
  logic [LEN_W-1:0]  payload_remaining, payload_remaining_next;
  logic              in_payload, in_payload_next;
  logic [MLEN_W-1:0] bytes_emitted, bytes_emitted_next;

  // Sequencer and datapath registers
  logic [PC_W-1:0]                  pc, pc_next;
  logic [LEN_W-1:0]                 conv_val;      // binary value being converted
  logic [BCD_DIGITS-1:0][3:0]       bcd;           // decimal digits, LSD at index 0
  logic [STEP_W-1:0]                step_cnt;      // shift-add-3 steps left
  logic [DIG_PTR_W-1:0]             dig_ptr;       // digit being emitted
  logic [BYTE_W-1:0]                data_q;        // latched payload byte
  logic [LEN_W-1:0]                 len_q;         // latched element length
  logic                             nil_q;         // current element is nil
  logic                             tail_q;        // CR LF closes this transaction
  logic                             done_q;        // message completes on last byte

  // -------------------------------------------------------------------------
  // Transaction decode (only used while idle)
  // -------------------------------------------------------------------------
  cmd_t              cmd;
  logic              in_accept;
  logic              bad;
  logic              finish;
  logic              tail_dec;
  logic [CNT_W-1:0]  count_inc;
  logic [PC_W-1:0]   entry_pc;

  assign cmd       = cmd_t'(command);
  assign in_stall  = (pc != PC_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign count_inc = element_count + CNT_W'(1);

  always_comb begin
    bad      = 1'b0;
    finish   = 1'b0;
    tail_dec = 1'b0;
    entry_pc = PC_IDLE;
    case (cmd)
      CMD_START: begin
        bad = count_or_length > LEN_W'(MAX_ELEMENTS);
      end
      CMD_BULK, CMD_NIL: begin
        bad = in_payload || (element_count >= element_total) ||
              ((cmd == CMD_BULK) && (count_or_length > LEN_W'(MAX_ELEMENT_LENGTH)));
        // a nil or empty element completes right away
        finish   = (cmd == CMD_NIL) || (count_or_length == '0);
        tail_dec = (count_or_length == '0);
        entry_pc = (element_count == '0) ? PC_HSTAR : PC_BDOLLAR;
      end
      CMD_DATA: begin
        bad      = !in_payload || (payload_remaining == '0);
        finish   = (payload_remaining == LEN_W'(1));
        tail_dec = finish;
        entry_pc = PC_DATA;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      entry_pc = PC_ERROR;
    end
  end

  // -------------------------------------------------------------------------
  // Microcode control
  // -------------------------------------------------------------------------
  ctrl_t ctrl;
  logic  emit_op;
  logic  slot_free;
  logic  step_go;
  logic  loop_more;

  assign ctrl      = ucode_rom(pc);
  assign slot_free = !out_valid || !out_stall;
  assign loop_more = (ctrl.uop == UOP_DABBLE) ? (step_cnt != STEP_W'(1)) : (dig_ptr != '0);

  always_comb begin
    emit_op = ctrl.uop inside {UOP_CHAR, UOP_DIGITS, UOP_DATA, UOP_ERROR};
    step_go = !emit_op || slot_free;
  end

  // next program counter
  always_comb begin
    pc_next = pc;
    if (pc == PC_IDLE) begin
      if (in_accept) begin
        pc_next = entry_pc;
      end
    end else if (step_go) begin
      case (ctrl.cond)
        COND_SEQ:    pc_next = pc + PC_W'(1);
        COND_ALWAYS: pc_next = ctrl.jmp;
        COND_LOOP:   pc_next = loop_more ? pc : pc + PC_W'(1);
        COND_NIL:    pc_next = nil_q ? ctrl.jmp : pc + PC_W'(1);
        COND_TAIL:   pc_next = tail_q ? ctrl.jmp : PC_IDLE;
        default:     pc_next = PC_IDLE;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Binary to BCD, one shift-add-3 step per cycle
  // -------------------------------------------------------------------------
  logic [BCD_DIGITS-1:0][3:0] bcd_adj;
  logic [BCD_DIGITS*4:0]      bcd_shift;
  logic [BCD_DIGITS-1:0][3:0] bcd_step;
  logic [DIG_PTR_W-1:0]       top_digit;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    // shift in the next binary bit; the top digit never overflows
    bcd_shift = {bcd_adj, conv_val[LEN_W-1]};
    bcd_step  = bcd_shift[BCD_DIGITS*4-1:0];
  end

  // highest nonzero digit of the finished conversion; zero prints as one digit
  always_comb begin
    top_digit = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_step[i] != 4'd0) begin
        top_digit = DIG_PTR_W'(i);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output byte and flags
  // -------------------------------------------------------------------------
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic [MLEN_W-1:0] bytes_inc;

  assign bytes_inc = (bytes_emitted == MLEN_MAX) ? bytes_emitted : bytes_emitted + MLEN_W'(1);

  always_comb begin
    case (ctrl.uop)
      UOP_CHAR:   emit_byte = ctrl.ch;
      UOP_DIGITS: emit_byte = CH_ZERO | {4'd0, bcd[dig_ptr]};
      UOP_DATA:   emit_byte = data_q;
      default:    emit_byte = CH_NONE;
    endcase
    case (ctrl.last_mode)
      LAST_YES:         emit_last = 1'b1;
      LAST_IF_NOT_TAIL: emit_last = !tail_q;
      default:          emit_last = 1'b0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Architectural state update
  // -------------------------------------------------------------------------
  always_comb begin
    element_total_next     = element_total;
    element_count_next     = element_count;
    payload_remaining_next = payload_remaining;
    in_payload_next        = in_payload;
    bytes_emitted_next     = bytes_emitted;
    if (in_accept && !bad) begin
      case (cmd)
        CMD_START: begin
          element_total_next     = count_or_length[CNT_W-1:0];
          element_count_next     = '0;
          payload_remaining_next = '0;
          in_payload_next        = 1'b0;
          bytes_emitted_next     = '0;
        end
        CMD_BULK, CMD_NIL: begin
          if (finish) begin
            element_count_next = count_inc;
          end else begin
            payload_remaining_next = count_or_length;
            in_payload_next        = 1'b1;
          end
        end
        default: begin
          payload_remaining_next = payload_remaining - LEN_W'(1);
          if (finish) begin
            in_payload_next    = 1'b0;
            element_count_next = count_inc;
          end
        end
      endcase
    end
    // error answers report the count but do not advance it
    if (emit_op && slot_free && (ctrl.uop != UOP_ERROR)) begin
      bytes_emitted_next = bytes_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_total     <= '0;
      element_count     <= '0;
      payload_remaining <= '0;
      in_payload        <= 1'b0;
      bytes_emitted     <= '0;
      pc                <= PC_IDLE;
      out_valid         <= 1'b0;
    end else begin
      element_total     <= element_total_next;
      element_count     <= element_count_next;
      payload_remaining <= payload_remaining_next;
      in_payload        <= in_payload_next;
      bytes_emitted     <= bytes_emitted_next;
      pc                <= pc_next;
      if (emit_op && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_q <= data_byte;
      len_q  <= count_or_length;
      nil_q  <= (cmd == CMD_NIL);
      tail_q <= tail_dec;
      done_q <= !bad && finish && (count_inc == element_total);
    end
    case (ctrl.uop)
      UOP_LOAD_TOTAL: begin
        conv_val <= LEN_W'(element_total);
        bcd      <= '0;
        step_cnt <= STEP_W'(LEN_W);
      end
      UOP_LOAD_LEN: begin
        conv_val <= len_q;
        bcd      <= '0;
        step_cnt <= STEP_W'(LEN_W);
      end
      UOP_DABBLE: begin
        conv_val <= conv_val << 1;
        bcd      <= bcd_step;
        step_cnt <= step_cnt - STEP_W'(1);
        if (step_cnt == STEP_W'(1)) begin
          dig_ptr <= top_digit;
        end
      end
      UOP_DIGITS: begin
        if (slot_free) begin
          dig_ptr <= dig_ptr - DIG_PTR_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (emit_op && slot_free) begin
      out_byte       <= emit_byte;
      last           <= emit_last;
      error          <= (ctrl.uop == UOP_ERROR);
      message_done   <= emit_last && done_q && (ctrl.uop != UOP_ERROR);
      message_length <= (ctrl.uop == UOP_ERROR) ? bytes_emitted : bytes_inc;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_IMPLY(a_err_shape, clk, rst, out_valid && error, last && !message_done && out_byte == CH_NONE, "error transaction not a lone zero byte")
  `ASSERT_IMPLY(a_done_last, clk, rst, out_valid && message_done, last && !error, "message_done off the final byte")
  `ASSERT_IMPLY(a_open_payload, clk, rst, in_payload, payload_remaining != '0, "open payload with nothing remaining")
  `ASSERT_ALWAYS(a_count_bound, clk, rst, element_count <= element_total, "element count ran past total")

endmodule

// File: sim/tb_resp_array_command_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_resp_array_command_encoder
// Self-checking bench for the RESP array command encoder: a queue-fed driver
// pushes commands through the valid/stall input, a scoreboard predicts the
// serialized byte stream and checks every output transaction in order.
// ---------------------------------------------------------------------------
module tb_resp_array_command_encoder;
  import race_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 200;   // covers two BCD passes plus stalls
  localparam int MAX_REPORTS  = 10;
  localparam int N_ITEMS      = 120;

  // One input transaction as queued for the driver.
  typedef struct {
    cmd_t               cmd;
    logic [LEN_W-1:0]   col;
    logic [BYTE_W-1:0]  db;
    bit                 drain;   // hold off until every output has arrived
  } encoder_cmd_t;

  // One expected output transaction.
  typedef struct {
    logic [BYTE_W-1:0]  out_byte;
    logic               last;
    logic               error;
    logic               message_done;
    logic [MLEN_W-1:0]  message_length;
  } resp_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           command = CMD_START;
  logic [LEN_W-1:0]     count_or_length = '0;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 last;
  logic                 error;
  logic                 message_done;
  logic [MLEN_W-1:0]    message_length;

  resp_array_command_encoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .count_or_length (count_or_length),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .last            (last),
    .error           (error),
    .message_done    (message_done),
    .message_length  (message_length)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Bookkeeping
  // -------------------------------------------------------------------------
  encoder_cmd_t  cmd_q[$];        // commands not yet presented
  resp_byte_t    resp_q[$];       // predicted bytes not yet seen
  logic [7:0]    serial_stage[$]; // bytes built for the current command

  int unsigned total_items = 0;
  int unsigned n_random = 0;
  int unsigned n_accepted = 0;
  int unsigned results_outstanding = 0;  // lagged copy of resp_q size for the driver
  int unsigned n_checked = 0;
  int unsigned n_err_seen = 0;
  int unsigned n_msg_done = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Idle mix: first third sender-light / receiver-heavy, second third the
  // reverse, last third full throughput.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  assign tx_idle_pct = (n_accepted < total_items / 3)     ? 18 :
                       (n_accepted < 2 * total_items / 3) ? 88 : 0;
  assign rx_idle_pct = (n_accepted < total_items / 3)     ? 88 :
                       (n_accepted < 2 * total_items / 3) ? 18 : 0;

  // -------------------------------------------------------------------------
  // Encoder prediction state
  // -------------------------------------------------------------------------
  logic [CNT_W-1:0]   elem_total = '0;
  logic [CNT_W-1:0]   elem_count = '0;
  logic [LEN_W-1:0]   pay_left   = '0;
  logic               pay_open   = 1'b0;
  logic [MLEN_W-1:0]  msg_bytes  = '0;

  // Decimal text with no leading zeros; zero prints as "0".
  task automatic stage_decimal(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) serial_stage.push_back(s[i]);
  endtask

  // Bumps the element counter; returns 1 when that closes the array.
  function automatic bit close_element();
    elem_count = elem_count + 1'b1;
    return (elem_count == elem_total);
  endfunction

  // Predicts the output bytes of one accepted command.
  task automatic encode_command(input cmd_t cmd, input logic [LEN_W-1:0] col,
                                input logic [BYTE_W-1:0] db);
    bit         bad;
    bit         done;
    resp_byte_t r;
    bad  = 1'b0;
    done = 1'b0;
    serial_stage.delete();
    case (cmd)
      CMD_START: begin
        if (col > MAX_ELEMENTS) begin
          bad = 1'b1;
        end else begin
          // valid start: counters cleared, nothing emitted
          elem_total = col[CNT_W-1:0];
          elem_count = '0;
          pay_left   = '0;
          pay_open   = 1'b0;
          msg_bytes  = '0;
          return;
        end
      end
      CMD_BULK, CMD_NIL: begin
        if (pay_open || elem_count >= elem_total) begin
          bad = 1'b1;   // payload still open, or no element left in the array
        end else if (cmd == CMD_BULK && col > MAX_ELEMENT_LENGTH) begin
          bad = 1'b1;
        end else begin
          if (elem_count == 0) begin
            serial_stage.push_back(CH_STAR);
            stage_decimal(elem_total);
            serial_stage.push_back(CH_CR);
            serial_stage.push_back(CH_LF);
          end
          serial_stage.push_back(CH_DOLLAR);
          if (cmd == CMD_NIL) begin
            serial_stage.push_back(CH_MINUS);
            serial_stage.push_back(CH_ONE);
            serial_stage.push_back(CH_CR);
            serial_stage.push_back(CH_LF);
            done = close_element();
          end else begin
            stage_decimal(col);
            serial_stage.push_back(CH_CR);
            serial_stage.push_back(CH_LF);
            if (col == 0) begin
              // empty element closes right away
              serial_stage.push_back(CH_CR);
              serial_stage.push_back(CH_LF);
              done = close_element();
            end else begin
              pay_left = col;
              pay_open = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!pay_open || pay_left == 0) begin
          bad = 1'b1;   // stray payload byte
        end else begin
          serial_stage.push_back(db);
          pay_left = pay_left - 1'b1;
          if (pay_left == 0) begin
            pay_open = 1'b0;
            serial_stage.push_back(CH_CR);
            serial_stage.push_back(CH_LF);
            done = close_element();
          end
        end
      end
    endcase

    if (bad) begin
      // error answer: single marker byte, state untouched
      r.out_byte       = CH_NONE;
      r.last           = 1'b1;
      r.error          = 1'b1;
      r.message_done   = 1'b0;
      r.message_length = msg_bytes;
      resp_q.push_back(r);
      return;
    end

    for (int k = 0; k < serial_stage.size(); k++) begin
      if (msg_bytes != MLEN_MAX) msg_bytes = msg_bytes + 1'b1;
      r.out_byte       = serial_stage[k];
      r.last           = (k == serial_stage.size() - 1);
      r.error          = 1'b0;
      r.message_done   = r.last && done;
      r.message_length = msg_bytes;
      resp_q.push_back(r);
    end
  endtask

  // -------------------------------------------------------------------------
  // Driver: presents queued commands, holds payload while stalled.
  // -------------------------------------------------------------------------
  encoder_cmd_t drv_next;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) n_accepted <= n_accepted + 1;
      // A drain-marked command waits on an idle cycle plus an empty scoreboard.
      if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
          !(cmd_q[0].drain && (in_valid || results_outstanding != 0))) begin
        drv_next = cmd_q.pop_front();
        in_valid        <= 1'b1;
        command         <= drv_next.cmd;
        count_or_length <= drv_next.col;
        data_byte       <= drv_next.db;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: predicts on each accepted input, then checks each output.
  // Prediction comes first so a same-edge result still finds its entry.
  // -------------------------------------------------------------------------
  resp_byte_t exp_r;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall)
        encode_command(cmd_t'(command), count_or_length, data_byte);
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected output: byte=%02h last=%b err=%b done=%b len=%0d",
                     $realtime, out_byte, last, error, message_done, message_length);
        end else begin
          exp_r = resp_q.pop_front();
          n_checked = n_checked + 1;
          if (exp_r.error) n_err_seen = n_err_seen + 1;
          if (exp_r.message_done) n_msg_done = n_msg_done + 1;
          if (out_byte !== exp_r.out_byte || last !== exp_r.last ||
              error !== exp_r.error || message_done !== exp_r.message_done ||
              message_length !== exp_r.message_length) begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
              $display("[%0t] mismatch #%0d: exp byte=%02h last=%b err=%b done=%b len=%0d",
                       $realtime, n_checked, exp_r.out_byte, exp_r.last, exp_r.error,
                       exp_r.message_done, exp_r.message_length);
            if (fail_count <= MAX_REPORTS)
              $display("               got byte=%02h last=%b err=%b done=%b len=%0d",
                       out_byte, last, error, message_done, message_length);
          end
        end
      end
      results_outstanding <= resp_q.size();
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  task automatic queue_cmd(input cmd_t cmd, input int unsigned col,
                           input logic [BYTE_W-1:0] db, input bit drain);
    encoder_cmd_t c;
    c.cmd   = cmd;
    c.col   = col[LEN_W-1:0];
    c.db    = db;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  function automatic int unsigned any_col();
    return $urandom & 32'h1FFFF;
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  // Rare drain requests scattered through the random part.
  function automatic bit maybe_drain();
    return ($urandom_range(99) < 3);
  endfunction

  // Mostly well-formed array with random content; some truncated payloads,
  // stray bytes, surplus elements and over-range counts.
  task automatic queue_random_message();
    int unsigned total, n_elem, len, nbytes, sel;
    sel = $urandom_range(99);
    if (sel < 6)       total = $urandom_range(131071, 1000);
    else if (sel < 16) total = $urandom_range(999, 5);
    else               total = $urandom_range(4, 1);
    queue_cmd(CMD_START, total, any_byte(), maybe_drain());
    n_random++;
    if (total > MAX_ELEMENTS) n_elem = $urandom_range(2, 0);
    else if (total > 4)       n_elem = $urandom_range(4, 1);
    else                      n_elem = total;
    if ($urandom_range(99) < 10) n_elem++;   // one extra element
    for (int k = 0; k < n_elem; k++) begin
      if ($urandom_range(99) < 25) begin
        queue_cmd(CMD_NIL, any_col(), any_byte(), maybe_drain());
        n_random++;
      end else begin
        sel = $urandom_range(99);
        if (sel < 65)      len = $urandom_range(5, 0);
        else if (sel < 90) len = $urandom_range(24, 6);
        else               len = $urandom_range(99999, 25);
        queue_cmd(CMD_BULK, len, any_byte(), maybe_drain());
        n_random++;
        sel = $urandom_range(99);
        if (len > 24)                nbytes = $urandom_range(3, 0);
        else if (sel < 8 && len > 0) nbytes = $urandom_range(len - 1, 0);
        else if (sel < 14)           nbytes = len + 1;   // stray trailing byte
        else                         nbytes = len;
        for (int j = 0; j < nbytes; j++) begin
          queue_cmd(CMD_DATA, any_col(), any_byte(), maybe_drain());
          n_random++;
        end
      end
    end
  endtask

  initial begin
    // --- directed ---
    queue_cmd(CMD_BULK,  5,       8'h11, 1'b0);  // element with zero count
    queue_cmd(CMD_DATA,  0,       8'hA5, 1'b0);  // stray byte
    queue_cmd(CMD_NIL,   17'h1FFFF, 8'h00, 1'b0);
    queue_cmd(CMD_START, 1000,    8'h00, 1'b0);  // count too large
    queue_cmd(CMD_START, 17'h1FFFF, 8'hFF, 1'b0);
    queue_cmd(CMD_START, 0,       8'h00, 1'b0);
    queue_cmd(CMD_NIL,   0,       8'h00, 1'b0);  // zero-count array
    queue_cmd(CMD_START, 999,     8'h00, 1'b0);  // widest head
    queue_cmd(CMD_BULK,  100000,  8'h00, 1'b0);  // length too large
    queue_cmd(CMD_BULK,  17'h1FFFF, 8'h00, 1'b0);
    queue_cmd(CMD_NIL,   0,       8'h00, 1'b0);  // head plus nil
    queue_cmd(CMD_BULK,  99999,   8'h00, 1'b0);  // widest length
    queue_cmd(CMD_DATA,  17'h1FFFF, 8'h00, 1'b0);
    queue_cmd(CMD_NIL,   0,       8'h00, 1'b0);  // payload still open
    queue_cmd(CMD_BULK,  3,       8'h00, 1'b0);
    queue_cmd(CMD_START, 3,       8'h00, 1'b1);  // abandon open payload
    queue_cmd(CMD_BULK,  0,       8'h00, 1'b0);  // empty element
    queue_cmd(CMD_BULK,  2,       8'h00, 1'b0);
    queue_cmd(CMD_DATA,  0,       8'hFF, 1'b0);
    queue_cmd(CMD_DATA,  0,       8'h00, 1'b0);
    queue_cmd(CMD_NIL,   0,       8'h00, 1'b0);  // closes the array
    queue_cmd(CMD_NIL,   0,       8'h00, 1'b0);  // past the end
    queue_cmd(CMD_DATA,  0,       8'h3C, 1'b0);
    queue_cmd(CMD_START, 1,       8'h00, 1'b1);
    queue_cmd(CMD_BULK,  1,       8'h00, 1'b0);
    queue_cmd(CMD_DATA,  0,       8'h5A, 1'b0);

    // --- random ---
    // directed items count toward the total
    n_random = cmd_q.size();
    while (n_random < N_ITEMS) begin
      if ($urandom_range(99) < 12) begin
        // noise: any command with any field values
        queue_cmd(cmd_t'($urandom_range(3)),
                  $urandom_range(1) ? any_col() : $urandom_range(12),
                  any_byte(), maybe_drain());
        n_random++;
      end else begin
        queue_random_message();
      end
    end
    total_items = cmd_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || in_valid) @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    if (resp_q.size() != 0) begin
      fail_count = fail_count + resp_q.size();
      $display("%0d predicted output bytes never arrived", resp_q.size());
    end
    $display("%0d commands sent, %0d output bytes checked in %0d cycles",
             total_items, n_checked, cycle_count);
    $display("%0d error answers and %0d completed arrays seen, %0d failures",
             n_err_seen, n_msg_done, fail_count);
    if (fail_count == 0) begin
      $display("resp_array_command_encoder regression: pass");
    end else begin
      $display("resp_array_command_encoder regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("watchdog expired after %0d cycles", cycle_count);
    $display("resp_array_command_encoder regression: fail");
    $finish;
  end

endmodule
